/* hw/rtl/hmct_pkg.sv */
package hmct_pkg;

  localparam int CAPACITY   = 4096;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int KEY_W      = 23;
  localparam int COST_W     = 8;
  localparam int ENTRY_W    = KEY_W + COST_W;
  localparam int FUNC_W     = 2;
  localparam int SLOT_IDX_W = 12;
  localparam int STATUS_W   = 3;
  localparam int OCC_W      = 12;
  localparam int CNT_W      = IDX_W;
  localparam int OCC_LIMIT  = CAPACITY - CAPACITY / 4;

  localparam logic [63:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_READ   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STS_NEW   = 3'd0;
  localparam logic [STATUS_W-1:0] STS_LOWER = 3'd1;
  localparam logic [STATUS_W-1:0] STS_KEPT  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_ZERO  = 3'd4;
  localparam logic [STATUS_W-1:0] STS_READ  = 3'd5;
  localparam logic [STATUS_W-1:0] STS_CLEAR = 3'd6;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_CLR_DONE,
    S_IDLE,
    S_READ,
    S_ZERO,
    S_HASH,
    S_PROBE
  } state_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] idx;
  } hash_res_t;

endpackage

/* hw/rtl/hmct_hash.sv */
module hmct_hash import hmct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output hash_res_t        res
);

  // Each 64-bit multiply is built from three 32-bit products on one shared multiplier.
  logic [63:0] a_r;
  logic [63:0] acc_r;
  logic [63:0] prod_r;
  logic [1:0]  step_r;
  logic        pass_r;
  logic        busy_r;
  logic        done_r;

  logic [63:0] pre;
  logic [63:0] mul_b;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] prod_c;
  logic [31:0] hi_sum;
  logic [63:0] y;

  assign pre    = 64'(key) + MIX_ADD;
  assign mul_b  = pass_r ? MIX_MUL2 : MIX_MUL1;
  assign prod_c = mul_x * mul_y;
  assign hi_sum = acc_r[63:32] + prod_r[31:0];
  assign y      = {hi_sum, acc_r[31:0]};

  always_comb begin
    unique case (step_r)
      2'd0: begin
        mul_x = a_r[31:0];
        mul_y = mul_b[31:0];
      end
      2'd1: begin
        mul_x = a_r[63:32];
        mul_y = mul_b[31:0];
      end
      2'd2: begin
        mul_x = a_r[31:0];
        mul_y = mul_b[63:32];
      end
      default: begin
        mul_x = a_r[31:0];
        mul_y = mul_b[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
      pass_r <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= pre ^ (pre >> 30);
        step_r <= 2'd0;
        pass_r <= 1'b0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        unique case (step_r)
          2'd0: begin
            prod_r <= prod_c;
          end
          2'd1: begin
            acc_r  <= prod_r;
            prod_r <= prod_c;
          end
          2'd2: begin
            acc_r[63:32] <= hi_sum;
            prod_r       <= prod_c;
          end
          default: begin
            if (!pass_r) begin
              a_r    <= y ^ (y >> 27);
              pass_r <= 1'b1;
            end else begin
              a_r    <= y ^ (y >> 31);
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign res.done = done_r;
  assign res.idx  = a_r[IDX_W-1:0];

endmodule

/* hw/rtl/hashed_min_cost_table.sv */
// Open-addressing table of 4096 slots that keeps the least cost seen for each nonzero key,
// with linear probing from a splitmix64 hash. One operation is handled at a time. After reset,
// and for every clear operation, a clearing pass writes all 4096 slots, one per cycle, while
// in_ready stays low. A slot read passes through the memory read register and then the
// result register. An insert runs the hash and then probes slot by slot: the hash runs on
// one shared 32-bit multiplier, three products for each of its two 64-bit multiplies, and
// the probe reads the slot memory through its single read port once per cycle. The result
// register lets the next operation be accepted while a result still waits for out_ready.
module hashed_min_cost_table import hmct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [KEY_W-1:0]      in_key,
  input  logic [COST_W-1:0]     in_cost,
  input  logic [SLOT_IDX_W-1:0] in_slot_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_slot_valid,
  output logic [KEY_W-1:0]      out_slot_key,
  output logic [COST_W-1:0]     out_slot_cost,
  output logic [OCC_W-1:0]      out_occupancy
);

  logic [ENTRY_W-1:0] mem [CAPACITY];
  logic [ENTRY_W-1:0] rd_data_r;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    addr_r, addr_nxt;
  logic [IDX_W-1:0]    probe_cnt_r, probe_cnt_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                clr_op_r, clr_op_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [COST_W-1:0]   cost_r, cost_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_slot_valid_r, out_slot_valid_nxt;
  logic [KEY_W-1:0]    out_slot_key_r, out_slot_key_nxt;
  logic [COST_W-1:0]   out_slot_cost_r, out_slot_cost_nxt;
  logic [OCC_W-1:0]    out_occ_r, out_occ_nxt;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;

  logic                hash_start;
  hash_res_t           hash_res;

  logic                out_free;
  logic                ld;
  logic [STATUS_W-1:0] ld_status;
  logic                ld_valid;
  logic [KEY_W-1:0]    ld_key;
  logic [COST_W-1:0]   ld_cost;
  logic [KEY_W-1:0]    ent_key;
  logic [COST_W-1:0]   ent_cost;

  hmct_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_key),
    .res   (hash_res)
  );

  assign ent_key  = rd_data_r[KEY_W-1:0];
  assign ent_cost = rd_data_r[ENTRY_W-1:KEY_W];
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    probe_cnt_nxt = probe_cnt_r;
    count_nxt     = count_r;
    clr_op_nxt    = clr_op_r;
    key_nxt       = key_r;
    cost_nxt      = cost_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = addr_r;
    hash_start    = 1'b0;
    ld            = 1'b0;
    ld_status     = STS_READ;
    ld_valid      = 1'b0;
    ld_key        = '0;
    ld_cost       = '0;

    unique case (state_r)
      S_SWEEP: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (&addr_r) begin
          state_nxt = clr_op_r ? S_CLR_DONE : S_IDLE;
        end
      end
      S_CLR_DONE: begin
        if (out_free) begin
          ld         = 1'b1;
          ld_status  = STS_CLEAR;
          clr_op_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          key_nxt  = in_key;
          cost_nxt = in_cost;
          if (in_func == FN_CLEAR) begin
            addr_nxt   = '0;
            count_nxt  = '0;
            clr_op_nxt = 1'b1;
            state_nxt  = S_SWEEP;
          end else if (in_func == FN_INSERT) begin
            if (in_key == '0) begin
              state_nxt = S_ZERO;
            end else begin
              hash_start = 1'b1;
              state_nxt  = S_HASH;
            end
          end else begin
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(in_slot_index);
            state_nxt = S_READ;
          end
        end
      end
      S_ZERO: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_status = STS_ZERO;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_status = STS_READ;
          if (ent_key != '0) begin
            ld_valid = 1'b1;
            ld_key   = ent_key;
            ld_cost  = ent_cost;
          end
          state_nxt = S_IDLE;
        end
      end
      S_HASH: begin
        if (hash_res.done) begin
          mem_re        = 1'b1;
          mem_raddr     = hash_res.idx;
          addr_nxt      = hash_res.idx;
          probe_cnt_nxt = '0;
          state_nxt     = S_PROBE;
        end
      end
      S_PROBE: begin
        if (ent_key == '0) begin
          if (out_free) begin
            ld        = 1'b1;
            state_nxt = S_IDLE;
            if (count_r >= CNT_W'(OCC_LIMIT)) begin
              ld_status = STS_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {cost_r, key_r};
              count_nxt = count_r + 1'b1;
              ld_status = STS_NEW;
              ld_valid  = 1'b1;
              ld_key    = key_r;
              ld_cost   = cost_r;
            end
          end
        end else if (ent_key == key_r) begin
          if (out_free) begin
            ld        = 1'b1;
            ld_valid  = 1'b1;
            ld_key    = key_r;
            state_nxt = S_IDLE;
            if (cost_r < ent_cost) begin
              mem_we    = 1'b1;
              mem_wdata = {cost_r, key_r};
              ld_status = STS_LOWER;
              ld_cost   = cost_r;
            end else begin
              ld_status = STS_KEPT;
              ld_cost   = ent_cost;
            end
          end
        end else if (&probe_cnt_r) begin
          if (out_free) begin
            ld        = 1'b1;
            ld_status = STS_FULL;
            state_nxt = S_IDLE;
          end
        end else begin
          addr_nxt      = addr_r + 1'b1;
          probe_cnt_nxt = probe_cnt_r + 1'b1;
          mem_re        = 1'b1;
          mem_raddr     = addr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt      = out_valid_r && !out_ready;
    out_status_nxt     = out_status_r;
    out_slot_valid_nxt = out_slot_valid_r;
    out_slot_key_nxt   = out_slot_key_r;
    out_slot_cost_nxt  = out_slot_cost_r;
    out_occ_nxt        = out_occ_r;
    if (ld) begin
      out_valid_nxt      = 1'b1;
      out_status_nxt     = ld_status;
      out_slot_valid_nxt = ld_valid;
      out_slot_key_nxt   = ld_key;
      out_slot_cost_nxt  = ld_cost;
      out_occ_nxt        = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      addr_r      <= '0;
      probe_cnt_r <= '0;
      count_r     <= '0;
      clr_op_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      probe_cnt_r <= probe_cnt_nxt;
      count_r     <= count_nxt;
      clr_op_r    <= clr_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r            <= key_nxt;
    cost_r           <= cost_nxt;
    out_status_r     <= out_status_nxt;
    out_slot_valid_r <= out_slot_valid_nxt;
    out_slot_key_r   <= out_slot_key_nxt;
    out_slot_cost_r  <= out_slot_cost_nxt;
    out_occ_r        <= out_occ_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_valid = out_slot_valid_r;
  assign out_slot_key   = out_slot_key_r;
  assign out_slot_cost  = out_slot_cost_r;
  assign out_occupancy  = out_occ_r;

endmodule

/* hw/rtl/hmct_checker.sv */
module hmct_checker import hmct_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [STATUS_W-1:0]   out_status,
  input logic                  out_slot_valid,
  input logic [KEY_W-1:0]      out_slot_key,
  input logic [COST_W-1:0]     out_slot_cost,
  input logic [OCC_W-1:0]      out_occupancy
);

  // The clearing pass after reset keeps the input side closed.
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input accepted during the clearing pass after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_slot_valid) && $stable(out_slot_key) && $stable(out_slot_cost) &&
      $stable(out_occupancy))
    else $error("result beat changed while stalled");

  a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STS_FULL || out_status == STS_ZERO ||
      out_status == STS_CLEAR) |-> !out_slot_valid && out_slot_key == '0 &&
      out_slot_cost == '0)
    else $error("refused or clear beat carries slot data");

  a_insert_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STS_NEW || out_status == STS_LOWER ||
      out_status == STS_KEPT) |-> out_slot_valid && out_slot_key != '0 &&
      out_occupancy <= OCC_W'(OCC_LIMIT))
    else $error("insert beat without a valid key or above the load limit");

  a_clear_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_CLEAR |-> out_occupancy == '0)
    else $error("clear beat reports nonzero occupancy");

endmodule

bind hashed_min_cost_table hmct_checker u_hmct_checker (.*);

/* verif/hashed_min_cost_table_tb.sv */
`timescale 1ns / 1ps

module hashed_min_cost_table_tb;
  import hmct_pkg::*;

  localparam logic [FUNC_W-1:0] FN_READ_ALT = 2'd3;
  localparam int FILL_LIMIT = CAPACITY * 3 / 4;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 200;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam logic [63:0] SPLIT_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SPLIT_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SPLIT_MUL_B = 64'h94d049bb133111eb;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [COST_W-1:0]   cost;
    logic [OCC_W-1:0]    occ;
  } slot_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func = FN_READ;
  logic [KEY_W-1:0]      in_key = '0;
  logic [COST_W-1:0]     in_cost = '0;
  logic [SLOT_IDX_W-1:0] in_slot_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_slot_valid;
  logic [KEY_W-1:0]      out_slot_key;
  logic [COST_W-1:0]     out_slot_cost;
  logic [OCC_W-1:0]      out_occupancy;

  logic [KEY_W-1:0]  tab_key [CAPACITY];
  logic [COST_W-1:0] tab_cost [CAPACITY];
  int unsigned       tab_used;
  slot_result_t      pending_results [$];
  int                mismatch_count = 0;
  int                status_seen [8];
  int                cycle_count = 0;
  int                ready_hold = 0;
  bit                quiet = 1'b0;

  hashed_min_cost_table dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_key        (in_key),
    .in_cost       (in_cost),
    .in_slot_index (in_slot_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_slot_valid(out_slot_valid),
    .out_slot_key  (out_slot_key),
    .out_slot_cost (out_slot_cost),
    .out_occupancy (out_occupancy)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] k);
    logic [63:0] v;
    v = 64'(k) + SPLIT_GAMMA;
    v = (v ^ (v >> 30)) * SPLIT_MUL_A;
    v = (v ^ (v >> 27)) * SPLIT_MUL_B;
    v = v ^ (v >> 31);
    return v[IDX_W-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] key_homed_at(input logic [IDX_W-1:0] slot,
                                                    input logic [KEY_W-1:0] start);
    logic [KEY_W-1:0] k;
    k = start;
    while (k == '0 || home_slot(k) != slot) k = k + 1'b1;
    return k;
  endfunction

  function automatic logic [IDX_W-1:0] locate_key(input logic [KEY_W-1:0] k);
    logic [IDX_W-1:0] p;
    p = home_slot(k);
    for (int n = 0; n < CAPACITY; n++) begin
      if (tab_key[p] == k || tab_key[p] == '0) return p;
      p = p + 1'b1;
    end
    return p;
  endfunction

  function automatic void wipe_table();
    foreach (tab_key[i]) begin
      tab_key[i] = '0;
      tab_cost[i] = '0;
    end
    tab_used = 0;
  endfunction

  function automatic slot_result_t apply_table_op(input logic [FUNC_W-1:0] fn,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [COST_W-1:0] c,
                                                  input logic [SLOT_IDX_W-1:0] si);
    slot_result_t r;
    logic [IDX_W-1:0] p;
    bit done;
    r = '0;
    done = 1'b0;
    if (fn == FN_CLEAR) begin
      wipe_table();
      r.status = STS_CLEAR;
    end else if (fn != FN_INSERT) begin
      p = si[IDX_W-1:0];
      r.status = STS_READ;
      if (tab_key[p] != '0) begin
        r.valid = 1'b1;
        r.key = tab_key[p];
        r.cost = tab_cost[p];
      end
    end else if (k == '0) begin
      r.status = STS_ZERO;
    end else begin
      p = home_slot(k);
      r.status = STS_FULL;
      for (int n = 0; n < CAPACITY && !done; n++) begin
        if (tab_key[p] == '0) begin
          if (tab_used < FILL_LIMIT) begin
            tab_key[p] = k;
            tab_cost[p] = c;
            tab_used++;
            r.status = STS_NEW;
            r.valid = 1'b1;
            r.key = k;
            r.cost = c;
          end
          done = 1'b1;
        end else if (tab_key[p] == k) begin
          r.valid = 1'b1;
          r.key = k;
          if (c < tab_cost[p]) begin
            tab_cost[p] = c;
            r.status = STS_LOWER;
          end else begin
            r.status = STS_KEPT;
          end
          r.cost = tab_cost[p];
          done = 1'b1;
        end
        p = p + 1'b1;
      end
    end
    r.occ = tab_used[OCC_W-1:0];
    return r;
  endfunction

  task automatic issue_op(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] k,
                          input logic [COST_W-1:0] c, input logic [SLOT_IDX_W-1:0] si);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= fn;
    in_key <= k;
    in_cost <= c;
    in_slot_index <= si;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_table_op(fn, k, c, si));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic compare_beat();
    slot_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with no operation outstanding, status %0d",
               $time, out_status);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      status_seen[want.status]++;
      check_field("status", 32'(want.status), 32'(out_status));
      check_field("slot_valid", 32'(want.valid), 32'(out_slot_valid));
      check_field("slot_key", 32'(want.key), 32'(out_slot_key));
      check_field("slot_cost", 32'(want.cost), 32'(out_slot_cost));
      check_field("occupancy", 32'(want.occ), 32'(out_occupancy));
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      compare_beat();
      ready_hold = draw_gap();
    end else if (ready_hold > 0) begin
      ready_hold--;
    end
    out_ready <= (ready_hold == 0);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_reset_reads();
    issue_op(FN_READ, '0, '0, '0);
    issue_op(FN_READ, '0, '0, '1);
    issue_op(FN_READ_ALT, KEY_MAX, COST_MAX, SLOT_IDX_W'($urandom_range(0, CAPACITY - 1)));
  endtask

  task automatic test_zero_key();
    issue_op(FN_INSERT, '0, COST_MAX, '1);
    issue_op(FN_INSERT, '0, '0, '0);
  endtask

  task automatic test_insert_extremes();
    issue_op(FN_INSERT, 23'd1, '0, '0);
    issue_op(FN_INSERT, KEY_MAX, COST_MAX, '1);
    issue_op(FN_INSERT, KEY_MAX, COST_MAX, '0);
    issue_op(FN_INSERT, KEY_MAX, COST_MAX - 1'b1, '0);
    issue_op(FN_INSERT, KEY_MAX, COST_MAX, '0);
    issue_op(FN_INSERT, 23'd1, '0, '0);
    issue_op(FN_READ, '0, '0, locate_key(KEY_MAX));
    issue_op(FN_READ, '0, '0, locate_key(23'd1));
  endtask

  task automatic test_probe_wrap();
    logic [KEY_W-1:0] ka, kb, kc;
    ka = key_homed_at(IDX_W'(CAPACITY - 1), KEY_W'($urandom_range(1, 23'h3fffff)));
    kb = key_homed_at(IDX_W'(CAPACITY - 1), ka + 1'b1);
    kc = key_homed_at('0, KEY_W'($urandom_range(1, 23'h3fffff)));
    issue_op(FN_INSERT, ka, 8'd100, '0);
    issue_op(FN_INSERT, kb, 8'd50, '0);
    issue_op(FN_INSERT, kc, 8'd70, '0);
    wait_results_drained();
    issue_op(FN_READ, '0, '0, '1);
    issue_op(FN_READ, '0, '0, '0);
    issue_op(FN_READ, '0, '0, 12'd1);
    issue_op(FN_INSERT, kb, 8'd20, '0);
    issue_op(FN_INSERT, kc, 8'd90, '0);
    wait_results_drained();
  endtask

  task automatic test_clear_table();
    logic [IDX_W-1:0] p;
    p = locate_key(KEY_MAX);
    issue_op(FN_CLEAR, '0, '0, '0);
    issue_op(FN_READ, '0, '0, p);
    issue_op(FN_READ, '0, '0, '0);
    issue_op(FN_CLEAR, KEY_MAX, COST_MAX, '1);
    issue_op(FN_READ_ALT, '0, '0, '1);
    wait_results_drained();
  endtask

  task automatic test_table_full();
    logic [KEY_W-1:0] held;
    int p_held, p_empty;
    issue_op(FN_CLEAR, '0, '0, '0);
    while (tab_used < FILL_LIMIT) begin
      quiet = (tab_used < FILL_LIMIT / 2);
      issue_op(FN_INSERT, KEY_W'($urandom_range(1, KEY_MAX)), COST_W'($urandom),
               SLOT_IDX_W'($urandom));
    end
    quiet = 1'b0;
    p_held = 0;
    while (tab_key[p_held] == '0) p_held++;
    p_empty = 0;
    while (tab_key[p_empty] != '0) p_empty++;
    held = tab_key[p_held];
    repeat (4) issue_op(FN_INSERT, KEY_W'($urandom_range(1, KEY_MAX)), COST_W'($urandom), '0);
    issue_op(FN_INSERT, held, '0, '0);
    issue_op(FN_INSERT, held, COST_MAX, '0);
    issue_op(FN_INSERT, '0, COST_MAX, '0);
    issue_op(FN_READ, '0, '0, SLOT_IDX_W'(p_held));
    issue_op(FN_READ, '0, '0, SLOT_IDX_W'(p_empty));
    repeat (24) issue_op(FN_READ, '0, '0, SLOT_IDX_W'($urandom));
    wait_results_drained();
  endtask

  task automatic test_random_mix();
    logic [KEY_W-1:0] key_pool [$];
    logic [KEY_W-1:0] k;
    int pick;
    repeat (40) key_pool.push_back(KEY_W'($urandom_range(1, KEY_MAX)));
    key_pool.push_back(23'd1);
    key_pool.push_back(KEY_MAX);
    key_pool.push_back(key_homed_at(IDX_W'(CAPACITY - 1), 23'd1));
    key_pool.push_back(key_homed_at(IDX_W'(CAPACITY - 1), key_pool[$] + 1'b1));
    issue_op(FN_CLEAR, '0, '0, '0);
    for (int i = 0; i < 800; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (pick < 50) begin
        issue_op(FN_INSERT, k, COST_W'($urandom), SLOT_IDX_W'($urandom));
      end else if (pick < 62) begin
        issue_op(FN_INSERT, KEY_W'($urandom), COST_W'($urandom), SLOT_IDX_W'($urandom));
      end else if (pick < 66) begin
        issue_op(FN_INSERT, '0, COST_W'($urandom), SLOT_IDX_W'($urandom));
      end else if (pick < 82) begin
        issue_op(FN_READ, KEY_W'($urandom), COST_W'($urandom), locate_key(k));
      end else if (pick < 92) begin
        issue_op(FN_READ, KEY_W'($urandom), COST_W'($urandom), SLOT_IDX_W'($urandom));
      end else if (pick < 99) begin
        issue_op(FN_READ_ALT, KEY_W'($urandom), COST_W'($urandom), SLOT_IDX_W'($urandom));
      end else begin
        issue_op(FN_CLEAR, KEY_W'($urandom), COST_W'($urandom), SLOT_IDX_W'($urandom));
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    wipe_table();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_reads();
    test_zero_key();
    test_insert_extremes();
    test_probe_wrap();
    test_clear_table();
    test_table_full();
    test_random_mix();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked results: %0d new keys, %0d lowered, %0d kept, %0d refused as full,",
             status_seen[STS_NEW], status_seen[STS_LOWER], status_seen[STS_KEPT],
             status_seen[STS_FULL]);
    $display("%0d zero keys, %0d slot reads, %0d clears; %0d mismatches.",
             status_seen[STS_ZERO], status_seen[STS_READ], status_seen[STS_CLEAR],
             mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
